// File: rtl/lsu_pkg.sv
package lsu_pkg;

	localparam int LSU_ADDR_BITS = 16;

	// instruction codes
	localparam logic [2:0] OP_LDA = 3'd0;
	localparam logic [2:0] OP_LDX = 3'd1;
	localparam logic [2:0] OP_LDY = 3'd2;
	localparam logic [2:0] OP_STA = 3'd3;
	localparam logic [2:0] OP_STX = 3'd4;
	localparam logic [2:0] OP_STY = 3'd5;

	// addressing mode codes
	localparam logic [3:0] MODE_IMM    = 4'd0;
	localparam logic [3:0] MODE_ZP     = 4'd1;
	localparam logic [3:0] MODE_ZP_X   = 4'd2;
	localparam logic [3:0] MODE_ZP_Y   = 4'd3;
	localparam logic [3:0] MODE_ABS    = 4'd4;
	localparam logic [3:0] MODE_ABS_X  = 4'd5;
	localparam logic [3:0] MODE_ABS_Y  = 4'd6;
	localparam logic [3:0] MODE_IND_X  = 4'd7;
	localparam logic [3:0] MODE_IND_Y  = 4'd8;

	// supported modes per instruction, bit m set for mode m
	localparam logic [15:0] LEGAL_MODES [8] = '{
		16'h01F7, 16'h005B, 16'h0037, 16'h01F6,
		16'h001A, 16'h0016, 16'h0000, 16'h0000
	};

	typedef enum logic [1:0] {
		CLS_ILLEGAL,
		CLS_IMM,
		CLS_DIRECT,
		CLS_INDIRECT
	} cls_t;

	// RAM address source
	typedef enum logic [1:0] {
		AS_CLR,
		AS_EA,
		AS_ZP_NEXT,
		AS_PTR
	} asrc_t;

	// datapath part of a microcode word
	typedef struct packed {
		logic  accept;
		logic  clr_wr;
		asrc_t asrc;
		logic  plo_ld;
		logic  access;
		logic  ea_ld;
		logic  fin;
	} dp_ctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic cmd_fire;
		cls_t cls;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

	function automatic cls_t lsu_class(input logic [2:0] op, input logic [3:0] mode);
		cls_t c;
		if (!LEGAL_MODES[op][mode])
			c = CLS_ILLEGAL;
		else if (mode == MODE_IMM)
			c = CLS_IMM;
		else if (mode == MODE_IND_X || mode == MODE_IND_Y)
			c = CLS_INDIRECT;
		else
			c = CLS_DIRECT;
		return c;
	endfunction

endpackage

// File: rtl/lsu_cmd_if.sv
interface lsu_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [3:0]  mode;
	logic [15:0] operand;

	modport source (output valid, op, mode, operand, input ready);
	modport sink (input valid, op, mode, operand, output ready);
endinterface

// File: rtl/lsu_res_if.sv
interface lsu_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  acc_value;
	logic [7:0]  x_value;
	logic [7:0]  y_value;
	logic        negative;
	logic        zero;
	logic [15:0] effective_address;
	logic [7:0]  moved_data;
	logic        illegal;

	modport source (output valid, acc_value, x_value, y_value, negative, zero,
		effective_address, moved_data, illegal, input ready);
	modport sink (input valid, acc_value, x_value, y_value, negative, zero,
		effective_address, moved_data, illegal, output ready);
endinterface

// File: rtl/lsu_ram.sv
module lsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

// File: rtl/lsu_useq.sv
module lsu_useq import lsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PTR_LO,
		ST_PTR_HI,
		ST_PTR_ACC,
		ST_ACCESS,
		ST_EXEC
	} step_t;

	typedef enum logic [2:0] {
		J_SEQ,
		J_GOTO,
		J_ACCEPT,
		J_CLEAR,
		J_RESULT
	} jmp_t;

	typedef struct packed {
		dp_ctl_t dp;
		jmp_t    jmp;
		step_t   tgt;
	} uword_t;

	// control store: accept, clr_wr, asrc, plo_ld, access, ea_ld, fin | jump | target
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		unique case (s)
			ST_CLEAR:   w = '{'{1'b0, 1'b1, AS_CLR,     1'b0, 1'b0, 1'b0, 1'b0}, J_CLEAR,  ST_IDLE};
			ST_IDLE:    w = '{'{1'b1, 1'b0, AS_EA,      1'b0, 1'b0, 1'b0, 1'b0}, J_ACCEPT, ST_IDLE};
			ST_PTR_LO:  w = '{'{1'b0, 1'b0, AS_EA,      1'b0, 1'b0, 1'b0, 1'b0}, J_SEQ,    ST_IDLE};
			ST_PTR_HI:  w = '{'{1'b0, 1'b0, AS_ZP_NEXT, 1'b1, 1'b0, 1'b0, 1'b0}, J_SEQ,    ST_IDLE};
			ST_PTR_ACC: w = '{'{1'b0, 1'b0, AS_PTR,     1'b0, 1'b1, 1'b1, 1'b0}, J_GOTO,   ST_EXEC};
			ST_ACCESS:  w = '{'{1'b0, 1'b0, AS_EA,      1'b0, 1'b1, 1'b0, 1'b0}, J_SEQ,    ST_IDLE};
			ST_EXEC:    w = '{'{1'b0, 1'b0, AS_EA,      1'b0, 1'b0, 1'b0, 1'b1}, J_RESULT, ST_IDLE};
			default:    w = '{'{1'b0, 1'b0, AS_EA,      1'b0, 1'b0, 1'b0, 1'b0}, J_GOTO,   ST_IDLE};
		endcase
		return w;
	endfunction

	function automatic step_t dispatch(input cls_t c);
		step_t s;
		unique case (c)
			CLS_ILLEGAL:  s = ST_EXEC;
			CLS_IMM:      s = ST_EXEC;
			CLS_DIRECT:   s = ST_ACCESS;
			CLS_INDIRECT: s = ST_PTR_LO;
			default:      s = ST_EXEC;
		endcase
		return s;
	endfunction

	step_t  step_q;
	step_t  step_n;
	uword_t uw;

	assign uw  = ucode(step_q);
	assign ctl = uw.dp;

	always_comb begin
		unique case (uw.jmp)
			J_SEQ:    step_n = step_t'(step_q + 3'd1);
			J_GOTO:   step_n = uw.tgt;
			J_ACCEPT: step_n = stat.cmd_fire ? dispatch(stat.cls) : step_q;
			J_CLEAR:  step_n = stat.clr_last ? uw.tgt : step_q;
			J_RESULT: step_n = stat.out_free ? uw.tgt : step_q;
			default:  step_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLEAR;
		end else begin
			step_q <= step_n;
		end
	end

`ifndef SYNTH
	a_fire_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cmd_fire |-> step_q == ST_IDLE)
		else $error("command taken outside idle step");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != ST_CLEAR |=> step_q != ST_CLEAR)
		else $error("clear pass restarted");
	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ST_PTR_LO |=> step_q == ST_PTR_HI)
		else $error("pointer fetch out of order");
`endif

endmodule

// File: rtl/lsu_dpath.sv
module lsu_dpath import lsu_pkg::*; #(
	parameter int ADDR_BITS = LSU_ADDR_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_ctl_t    ctl,
	output dp_stat_t   stat,
	lsu_cmd_if.sink    cmd,
	lsu_res_if.source  res
);

	localparam int DEPTH = 1 << ADDR_BITS;

	typedef struct packed {
		logic [7:0]  acc;
		logic [7:0]  x;
		logic [7:0]  y;
		logic        n;
		logic        z;
		logic [15:0] ea;
		logic [7:0]  data;
		logic        ill;
	} res_t;

	// architectural state
	logic [7:0] a_q, x_q, y_q;
	logic       n_q, z_q;

	// per-instruction registers
	logic [2:0]           op_q;
	logic [3:0]           mode_q;
	logic [7:0]           lo_q;
	logic                 ill_q;
	logic [ADDR_BITS-1:0] ea_q;
	logic [7:0]           plo_q;
	logic [ADDR_BITS-1:0] clr_q;

	logic out_valid_q;
	res_t res_q;

	logic                 cmd_fire;
	logic                 out_free;
	logic                 fire;
	logic                 is_store;
	logic [7:0]           zp_sum;
	logic [15:0]          abs_sum;
	logic [15:0]          entry_ea;
	logic [7:0]           zp_next;
	logic [15:0]          ptr_sum;
	logic [ADDR_BITS-1:0] ram_addr;
	logic                 we;
	logic [7:0]           wdata;
	logic [7:0]           rdata;
	logic [7:0]           st_data;
	logic [7:0]           ld_data;
	logic [7:0]           a_n, x_n, y_n;
	logic                 n_n, z_n;

	function automatic logic [7:0] idx_zp(input logic [3:0] m, input logic [7:0] x,
		input logic [7:0] y);
		logic [7:0] r;
		if (m == MODE_ZP_X || m == MODE_IND_X)
			r = x;
		else if (m == MODE_ZP_Y)
			r = y;
		else
			r = 8'd0;
		return r;
	endfunction

	function automatic logic [7:0] idx_abs(input logic [3:0] m, input logic [7:0] x,
		input logic [7:0] y);
		logic [7:0] r;
		if (m == MODE_ABS_X)
			r = x;
		else if (m == MODE_ABS_Y || m == MODE_IND_Y)
			r = y;
		else
			r = 8'd0;
		return r;
	endfunction

	assign cmd.ready = ctl.accept;
	assign cmd_fire  = ctl.accept & cmd.valid;
	assign out_free  = !out_valid_q || res.ready;
	assign fire      = ctl.fin & out_free;

	assign stat.cmd_fire = cmd_fire;
	assign stat.cls      = lsu_class(cmd.op, cmd.mode);
	assign stat.clr_last = &clr_q;
	assign stat.out_free = out_free;

	// address at entry: target for direct modes, pointer location for indirect ones, zero for immediate
	assign zp_sum  = cmd.operand[7:0] + idx_zp(cmd.mode, x_q, y_q);
	assign abs_sum = cmd.operand + {8'd0, idx_abs(cmd.mode, x_q, y_q)};

	always_comb begin
		if (cmd.mode == MODE_IMM)
			entry_ea = 16'd0;
		else if (cmd.mode == MODE_ABS || cmd.mode == MODE_ABS_X || cmd.mode == MODE_ABS_Y)
			entry_ea = abs_sum;
		else
			entry_ea = {8'd0, zp_sum};
	end

	assign zp_next = ea_q[7:0] + 8'd1;
	assign ptr_sum = {rdata, plo_q} + {8'd0, idx_abs(mode_q, x_q, y_q)};

	always_comb begin
		unique case (ctl.asrc)
			AS_CLR:     ram_addr = clr_q;
			AS_EA:      ram_addr = ea_q;
			AS_ZP_NEXT: ram_addr = ADDR_BITS'(zp_next);
			AS_PTR:     ram_addr = ADDR_BITS'(ptr_sum);
			default:    ram_addr = ea_q;
		endcase
	end

	assign is_store = (op_q == OP_STA) || (op_q == OP_STX) || (op_q == OP_STY);

	always_comb begin
		unique case (op_q)
			OP_STX:  st_data = x_q;
			OP_STY:  st_data = y_q;
			default: st_data = a_q;
		endcase
	end

	assign we    = ctl.clr_wr | (ctl.access & is_store);
	assign wdata = ctl.clr_wr ? 8'd0 : st_data;

	lsu_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	assign ld_data = (mode_q == MODE_IMM) ? lo_q : rdata;

	always_comb begin
		a_n = a_q;
		x_n = x_q;
		y_n = y_q;
		n_n = n_q;
		z_n = z_q;
		if (!ill_q && !is_store) begin
			unique case (op_q)
				OP_LDA:  a_n = ld_data;
				OP_LDX:  x_n = ld_data;
				OP_LDY:  y_n = ld_data;
				default: a_n = a_q;
			endcase
			n_n = ld_data[7];
			z_n = (ld_data == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q         <= 8'd0;
			x_q         <= 8'd0;
			y_q         <= 8'd0;
			n_q         <= 1'b0;
			z_q         <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_wr)
				clr_q <= clr_q + ADDR_BITS'(1);
			if (fire) begin
				a_q <= a_n;
				x_q <= x_n;
				y_q <= y_n;
				n_q <= n_n;
				z_q <= z_n;
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q   <= cmd.op;
			mode_q <= cmd.mode;
			lo_q   <= cmd.operand[7:0];
			ill_q  <= (stat.cls == CLS_ILLEGAL);
			ea_q   <= ADDR_BITS'(entry_ea);
		end else if (ctl.ea_ld) begin
			ea_q <= ADDR_BITS'(ptr_sum);
		end
		if (ctl.plo_ld)
			plo_q <= rdata;
		if (fire) begin
			res_q.acc  <= a_n;
			res_q.x    <= x_n;
			res_q.y    <= y_n;
			res_q.n    <= n_n;
			res_q.z    <= z_n;
			res_q.ea   <= ill_q ? 16'd0 : 16'(ea_q);
			res_q.data <= ill_q ? 8'd0 : (is_store ? st_data : ld_data);
			res_q.ill  <= ill_q;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.acc_value         = res_q.acc;
	assign res.x_value           = res_q.x;
	assign res.y_value           = res_q.y;
	assign res.negative          = res_q.n;
	assign res.zero              = res_q.z;
	assign res.effective_address = res_q.ea;
	assign res.moved_data        = res_q.data;
	assign res.illegal           = res_q.ill;

`ifndef SYNTH
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |-> !we)
		else $error("memory written while waiting for a command");
	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.illegal |-> res.effective_address == 16'd0 && res.moved_data == 8'd0)
		else $error("illegal result carries address or data");
	a_load_flags: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !ill_q && !is_store |=> res.zero == (res.moved_data == 8'd0)
			&& res.negative == res.moved_data[7])
		else $error("load flags disagree with loaded byte");
`endif

endmodule

// File: rtl/cpu_load_store_unit.sv
// Channel  Role   Transfer when      Payload
// cmd      sink   valid && ready     op, mode, operand
// res      source valid && ready     acc/x/y values, N, Z, effective_address, moved_data, illegal
//
// After reset a clear pass writes zero to all 2**ADDR_BITS bytes, one per cycle; cmd.ready
// stays low until the pass is done.
// One instruction at a time, sequenced by a microcode store over one single-port byte RAM.
// Immediate or illegal go straight to the result step, direct modes do the data access
// first, indirect modes two pointer reads then the data access on the same RAM port.
// A finished result sits in the output register; the next command is taken meanwhile and
// stalls only at its own result step while res is still full.
module cpu_load_store_unit import lsu_pkg::*; #(
	parameter int ADDR_BITS = LSU_ADDR_BITS
) (
	input logic       clk,
	input logic       arst_n,
	lsu_cmd_if.sink   cmd,
	lsu_res_if.source res
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	lsu_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	lsu_dpath #(
		.ADDR_BITS (ADDR_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat),
		.cmd    (cmd),
		.res    (res)
	);

endmodule
